/* design/lin_channel_mode_supervisor_unit_assert.svh */
// Assertion macros shared by the LIN channel mode supervisor modules.
`ifndef LIN_CHANNEL_MODE_SUPERVISOR_UNIT_ASSERT_SVH
`define LIN_CHANNEL_MODE_SUPERVISOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// The property must hold at every clock edge outside reset.
`define LCMS_CHECK(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("lcms assertion failed");
// When the antecedent holds, the consequent must hold in the next clock cycle.
`define LCMS_CHECK_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lcms assertion failed");
`else
`define LCMS_CHECK(label, prop)
`define LCMS_CHECK_NEXT(label, ante, cons)
`endif
`endif

/* design/lcms_pkg.sv */
// Types, codes and sizes shared by the LIN channel mode supervisor modules.
package lcms_pkg;

   localparam int NUM_CHANNELS     = 4;
   localparam int CHAN_IDX_W       = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int NUM_TIMEOUT_REGS = 4;
   localparam int NUM_TIMERS       = 3;

   localparam int CMD_W      = 3;
   localparam int CHAN_W     = 3;
   localparam int MODE_W     = 2;
   localparam int SCHED_W    = 6;
   localparam int ERR_W      = 3;
   localparam int TIMER_W    = 16;
   localparam int PERIOD_W   = 8;
   localparam int SCHED_MAP_W = 1 << SCHED_W;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;

   typedef enum logic [CMD_W-1:0] {
      CMD_INIT       = 3'd0,
      CMD_DEINIT     = 3'd1,
      CMD_SCHED_REQ  = 3'd2,
      CMD_MODE_REQ   = 3'd3,
      CMD_SCHED_CONF = 3'd4,
      CMD_WAKE_CONF  = 3'd5,
      CMD_SLEEP_CONF = 3'd6,
      CMD_TICK       = 3'd7
   } cmd_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_NO_COM  = 2'd0,
      MODE_SILENT  = 2'd1,
      MODE_FULL    = 2'd2,
      MODE_INVALID = 2'd3
   } mode_type;

   typedef enum logic [ERR_W-1:0] {
      ERR_OK         = 3'd0,
      ERR_REFUSED    = 3'd1,
      ERR_UNINIT     = 3'd2,
      ERR_NO_CHANNEL = 3'd3,
      ERR_BAD_PARAM  = 3'd4,
      ERR_TIMEOUT    = 3'd5
   } err_type;

   typedef enum logic [1:0] {
      TMR_SCHED = 2'd0,
      TMR_SLEEP = 2'd1,
      TMR_WAKE  = 2'd2
   } tmr_sel_type;

   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_COUNT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TICK_PERIOD   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT0      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT1      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT2      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT3      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_VALID_SCHED   = 3'd6;

   typedef struct packed {
      logic [CMD_W-1:0]   command;
      logic [CHAN_W-1:0]  chan;
      logic [MODE_W-1:0]  req_mode;
      logic [SCHED_W-1:0] sched_id;
      logic               success;
      logic               lower_ok;
   } req_type;

   typedef struct packed {
      logic [ERR_W-1:0]   error_code;
      logic [CHAN_W-1:0]  out_chan;
      logic               comm_ind_valid;
      logic               comm_ind_full;
      logic               state_ind_valid;
      logic               state_ind_full;
      logic               sched_ind_valid;
      logic [SCHED_W-1:0] sched_ind;
      logic               chan_is_full;
      logic               last;
   } rsp_type;

   // Effective configuration as the sequencer sees it.
   typedef struct packed {
      logic [CHAN_W-1:0]                     count;
      logic [PERIOD_W-1:0]                   period;
      logic [NUM_CHANNELS-1:0][TIMER_W-1:0]  timeout;
      logic [SCHED_MAP_W-1:0]                valid_sched;
   } cfg_type;

endpackage

/* design/lcms_sub_cmp.sv */
// Shared timer subtract and compare unit of the LIN channel mode supervisor.
module lcms_sub_cmp import lcms_pkg::*; (
   input  logic [TIMER_W-1:0] minuend,
   input  logic [TIMER_W-1:0] subtrahend,
   output logic [TIMER_W-1:0] diff,
   output logic               ge
);

   logic [TIMER_W:0] wide;

   assign wide = {1'b0, minuend} - {1'b0, subtrahend};
   assign diff = wide[TIMER_W-1:0];
   assign ge   = ~wide[TIMER_W];

endmodule

/* design/lcms_csr.sv */
// Configuration registers of the LIN channel mode supervisor.
module lcms_csr import lcms_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output cfg_type               cfg
);

   logic [CHAN_W-1:0]      count_ff, count_in;
   logic [PERIOD_W-1:0]    period_ff, period_in;
   logic [NUM_TIMEOUT_REGS-1:0][TIMER_W-1:0] timeout_ff, timeout_in;
   logic [SCHED_MAP_W-1:0] valid_ff, valid_in;

   assign csr_ready = 1'b1;

   always_comb begin
      count_in   = count_ff;
      period_in  = period_ff;
      timeout_in = timeout_ff;
      valid_in   = valid_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_CHANNEL_COUNT: count_in      = csr_data[CHAN_W-1:0];
            CSR_TICK_PERIOD:   period_in     = csr_data[PERIOD_W-1:0];
            CSR_TIMEOUT0:      timeout_in[0] = csr_data[TIMER_W-1:0];
            CSR_TIMEOUT1:      timeout_in[1] = csr_data[TIMER_W-1:0];
            CSR_TIMEOUT2:      timeout_in[2] = csr_data[TIMER_W-1:0];
            CSR_TIMEOUT3:      timeout_in[3] = csr_data[TIMER_W-1:0];
            CSR_VALID_SCHED:   valid_in      = csr_data[SCHED_MAP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         period_ff  <= PERIOD_W'(10);
         timeout_ff <= '0;
         valid_ff   <= SCHED_MAP_W'(1);
      end else begin
         count_ff   <= count_in;
         period_ff  <= period_in;
         timeout_ff <= timeout_in;
         valid_ff   <= valid_in;
      end
   end

   // A count above the built channels saturates, and a zero period acts as one.
   always_comb begin
      cfg.count  = (count_ff > CHAN_W'(NUM_CHANNELS)) ? CHAN_W'(NUM_CHANNELS) : count_ff;
      cfg.period = (period_ff == '0) ? PERIOD_W'(1) : period_ff;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         cfg.timeout[i] = timeout_ff[i];
      end
      cfg.valid_sched = valid_ff;
   end

endmodule

/* design/lcms_core.sv */
// Command sequencer and per-channel state of the LIN channel mode supervisor.
`include "lin_channel_mode_supervisor_unit_assert.svh"

module lcms_core import lcms_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    req_valid,
   input  req_type req_payload,
   output logic    busy,
   output logic    res_valid,
   input  logic    res_ready,
   output rsp_type res
);

   typedef enum logic [7:0] {
      S_IDLE     = 8'b0000_0001,
      S_CMP_A    = 8'b0000_0010,
      S_CMP_B    = 8'b0000_0100,
      S_EXEC     = 8'b0000_1000,
      S_TK_ACK   = 8'b0001_0000,
      S_TK_SUB   = 8'b0010_0000,
      S_TK_CHK   = 8'b0100_0000,
      S_TK_CLOSE = 8'b1000_0000
   } seq_state_type;

   seq_state_type           state_ff, state_in;
   req_type                 req_ff, req_in;
   logic [CHAN_IDX_W-1:0]   k_ff, k_in;
   tmr_sel_type             sel_ff, sel_in;
   logic                    ge_a_ff, ge_a_in;
   logic                    ge_b_ff, ge_b_in;
   logic                    hit_ff, hit_in;
   logic                    ready_ff, ready_in;
   logic [NUM_CHANNELS-1:0] full_ff, full_in;
   logic [NUM_CHANNELS-1:0] aok_ff, aok_in;
   logic [NUM_CHANNELS-1:0][SCHED_W-1:0] cur_ff, cur_in;
   logic [NUM_CHANNELS-1:0][SCHED_W-1:0] pend_ff, pend_in;
   logic [NUM_CHANNELS-1:0][NUM_TIMERS-1:0][TIMER_W-1:0] timer_ff, timer_in;

   logic                  walk;
   logic [CHAN_IDX_W-1:0] c_idx;
   logic [CHAN_IDX_W-1:0] rd_idx;
   logic [TIMER_W-1:0]    tmo;
   logic                  timing_off;
   logic                  chan_exists;
   logic                  last_chan;
   tmr_sel_type           sel_a;
   tmr_sel_type           op_sel;
   logic [TIMER_W-1:0]    sub_a;
   logic [TIMER_W-1:0]    sub_diff;
   logic                  sub_ge;

   assign walk = (state_ff == S_TK_ACK) || (state_ff == S_TK_SUB) || (state_ff == S_TK_CHK);
   assign c_idx       = req_ff.chan[CHAN_IDX_W-1:0];
   assign rd_idx      = walk ? k_ff : c_idx;
   assign tmo         = cfg.timeout[rd_idx];
   assign timing_off  = (tmo == '0);
   assign chan_exists = (req_ff.chan < cfg.count);
   assign last_chan   = ((CHAN_W'(k_ff) + CHAN_W'(1)) == cfg.count);
   assign busy        = (state_ff != S_IDLE);

   // The first compare looks at the timer that the command guards on.
   always_comb begin
      if ((req_ff.command == CMD_MODE_REQ) || (req_ff.command == CMD_WAKE_CONF)) begin
         sel_a = TMR_WAKE;
      end else if (req_ff.command == CMD_SLEEP_CONF) begin
         sel_a = TMR_SLEEP;
      end else begin
         sel_a = TMR_SCHED;
      end
      if (state_ff == S_CMP_A) begin
         op_sel = sel_a;
      end else if (state_ff == S_CMP_B) begin
         op_sel = TMR_SLEEP;
      end else begin
         op_sel = sel_ff;
      end
   end

   assign sub_a = timer_ff[rd_idx][op_sel];

   lcms_sub_cmp u_sub_cmp (
      .minuend    (sub_a),
      .subtrahend (TIMER_W'(cfg.period)),
      .diff       (sub_diff),
      .ge         (sub_ge)
   );

   always_comb begin : seq_comb
      logic               do_init, do_deinit, wr_pend, wr_cur, wr_full, full_val;
      logic               clr_aok, wr_tmr, take_a, sched_bad, mode_busy;
      tmr_sel_type        tmr_wsel;
      logic [TIMER_W-1:0] tmr_val;
      logic [ERR_W-1:0]   r_err;
      logic [CHAN_W-1:0]  r_chan;
      logic               r_ind_v, r_ind_f, r_sch_v, r_full, r_last;
      logic [SCHED_W-1:0] r_sch;

      state_in = state_ff;
      req_in   = req_ff;
      k_in     = k_ff;
      sel_in   = sel_ff;
      ge_a_in  = ge_a_ff;
      ge_b_in  = ge_b_ff;
      hit_in   = hit_ff;
      ready_in = ready_ff;
      full_in  = full_ff;
      aok_in   = aok_ff;
      cur_in   = cur_ff;
      pend_in  = pend_ff;
      timer_in = timer_ff;

      do_init   = 1'b0;
      do_deinit = 1'b0;
      wr_pend   = 1'b0;
      wr_cur    = 1'b0;
      wr_full   = 1'b0;
      full_val  = 1'b0;
      clr_aok   = 1'b0;
      wr_tmr    = 1'b0;
      tmr_wsel  = TMR_SCHED;
      tmr_val   = '0;
      take_a    = ge_a_ff || timing_off;
      sched_bad = (req_ff.sched_id != '0) && !cfg.valid_sched[req_ff.sched_id];
      mode_busy = !timing_off && (ge_a_ff || ge_b_ff);

      res_valid = 1'b0;
      r_err     = ERR_OK;
      r_chan    = req_ff.chan;
      r_ind_v   = 1'b0;
      r_ind_f   = 1'b0;
      r_sch_v   = 1'b0;
      r_sch     = '0;
      r_full    = 1'b0;
      r_last    = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_payload;
               state_in = S_CMP_A;
            end
         end
         S_CMP_A: begin
            ge_a_in  = sub_ge;
            state_in = S_CMP_B;
         end
         S_CMP_B: begin
            ge_b_in = sub_ge;
            if ((req_ff.command == CMD_TICK) && ready_ff) begin
               k_in     = '0;
               state_in = (cfg.count == '0) ? S_TK_CLOSE : S_TK_ACK;
            end else begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            res_valid = 1'b1;
            r_last    = 1'b1;
            if (req_ff.command == CMD_INIT) begin
               do_init = 1'b1;
            end else if (req_ff.command == CMD_DEINIT) begin
               do_deinit = 1'b1;
            end else if (!ready_ff) begin
               r_err = ERR_UNINIT;
            end else if (!chan_exists) begin
               r_err = ERR_NO_CHANNEL;
            end else begin
               r_full = full_ff[c_idx];
               unique case (req_ff.command)
                  CMD_SCHED_REQ: begin
                     if (sched_bad) begin
                        r_err = ERR_BAD_PARAM;
                     end else if (ge_a_ff || !full_ff[c_idx]) begin
                        r_err = ERR_REFUSED;
                     end else begin
                        wr_pend  = 1'b1;
                        wr_tmr   = 1'b1;
                        tmr_wsel = TMR_SCHED;
                        if (req_ff.lower_ok) begin
                           tmr_val = tmo;
                        end else begin
                           clr_aok = 1'b1;
                           r_err   = ERR_REFUSED;
                        end
                     end
                  end
                  CMD_MODE_REQ: begin
                     if (req_ff.req_mode == MODE_INVALID) begin
                        r_err = ERR_BAD_PARAM;
                     end else if (((req_ff.req_mode == MODE_NO_COM) && !full_ff[c_idx]) ||
                                  ((req_ff.req_mode == MODE_FULL) && full_ff[c_idx]) ||
                                  mode_busy || (req_ff.req_mode == MODE_SILENT)) begin
                        r_err = ERR_REFUSED;
                     end else begin
                        wr_tmr   = 1'b1;
                        tmr_wsel = (req_ff.req_mode == MODE_NO_COM) ? TMR_SLEEP : TMR_WAKE;
                        if (req_ff.lower_ok) begin
                           tmr_val = tmo;
                        end else begin
                           // The channel stays where it was, and says so.
                           r_err   = ERR_REFUSED;
                           r_ind_v = 1'b1;
                           r_ind_f = (req_ff.req_mode == MODE_NO_COM);
                        end
                     end
                  end
                  CMD_SCHED_CONF: begin
                     wr_tmr   = 1'b1;
                     tmr_wsel = TMR_SCHED;
                     if (pend_ff[c_idx] == req_ff.sched_id) begin
                        if (take_a) begin
                           wr_cur  = 1'b1;
                           r_sch_v = 1'b1;
                           r_sch   = pend_ff[c_idx];
                        end
                     end else begin
                        r_sch_v = 1'b1;
                        r_sch   = req_ff.sched_id;
                     end
                  end
                  CMD_WAKE_CONF: begin
                     wr_tmr   = 1'b1;
                     tmr_wsel = TMR_WAKE;
                     if (take_a) begin
                        wr_full  = 1'b1;
                        full_val = req_ff.success;
                        r_full   = req_ff.success;
                        r_ind_v  = 1'b1;
                        r_ind_f  = req_ff.success;
                     end
                  end
                  CMD_SLEEP_CONF: begin
                     wr_tmr   = 1'b1;
                     tmr_wsel = TMR_SLEEP;
                     if (take_a) begin
                        wr_full  = 1'b1;
                        full_val = !req_ff.success;
                        r_full   = !req_ff.success;
                        r_ind_v  = 1'b1;
                        r_ind_f  = !req_ff.success;
                     end
                  end
                  default: begin
                  end
               endcase
            end
            if (res_ready) begin
               state_in = S_IDLE;
               if (do_init) begin
                  ready_in = 1'b1;
                  full_in  = '0;
                  aok_in   = '1;
                  cur_in   = '0;
                  pend_in  = '0;
                  timer_in = '0;
               end
               if (do_deinit) begin
                  ready_in = 1'b0;
               end
               if (wr_pend) begin
                  pend_in[c_idx] = req_ff.sched_id;
               end
               if (wr_cur) begin
                  cur_in[c_idx] = pend_ff[c_idx];
               end
               if (wr_full) begin
                  full_in[c_idx] = full_val;
               end
               if (clr_aok) begin
                  aok_in[c_idx] = 1'b0;
               end
               if (wr_tmr) begin
                  timer_in[c_idx][tmr_wsel] = tmr_val;
               end
            end
         end
         S_TK_ACK: begin
            sel_in = TMR_SCHED;
            r_chan = CHAN_W'(k_ff);
            r_full = full_ff[k_ff];
            if (timing_off) begin
               if (last_chan) begin
                  state_in = S_TK_CLOSE;
               end else begin
                  k_in     = k_ff + CHAN_IDX_W'(1);
                  state_in = S_TK_ACK;
               end
            end else if (!aok_ff[k_ff]) begin
               // A schedule request the lower layer refused is reported once.
               res_valid = 1'b1;
               r_sch_v   = 1'b1;
               r_sch     = cur_ff[k_ff];
               if (res_ready) begin
                  aok_in[k_ff] = 1'b1;
                  state_in     = S_TK_SUB;
               end
            end else begin
               state_in = S_TK_SUB;
            end
         end
         S_TK_SUB: begin
            hit_in = sub_ge;
            if (sub_ge) begin
               timer_in[k_ff][sel_ff] = sub_diff;
            end
            state_in = S_TK_CHK;
         end
         S_TK_CHK: begin
            r_chan = CHAN_W'(k_ff);
            r_full = full_ff[k_ff];
            r_err  = ERR_TIMEOUT;
            unique case (sel_ff)
               TMR_SCHED: begin
                  r_sch_v = 1'b1;
                  r_sch   = cur_ff[k_ff];
               end
               TMR_SLEEP: begin
                  r_ind_v = 1'b1;
                  r_ind_f = 1'b1;
               end
               default: begin
                  r_ind_v = 1'b1;
                  r_ind_f = 1'b0;
               end
            endcase
            res_valid = hit_ff && !sub_ge;
            if (res_ready || !res_valid) begin
               if (sel_ff == TMR_WAKE) begin
                  if (last_chan) begin
                     state_in = S_TK_CLOSE;
                  end else begin
                     k_in     = k_ff + CHAN_IDX_W'(1);
                     state_in = S_TK_ACK;
                  end
               end else begin
                  sel_in   = (sel_ff == TMR_SCHED) ? TMR_SLEEP : TMR_WAKE;
                  state_in = S_TK_SUB;
               end
            end
         end
         S_TK_CLOSE: begin
            res_valid = 1'b1;
            r_last    = 1'b1;
            r_full    = ready_ff && chan_exists && full_ff[c_idx];
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      res.error_code      = r_err;
      res.out_chan        = r_chan;
      res.comm_ind_valid  = r_ind_v;
      res.comm_ind_full   = r_ind_v && r_ind_f;
      res.state_ind_valid = r_ind_v;
      res.state_ind_full  = r_ind_v && r_ind_f;
      res.sched_ind_valid = r_sch_v;
      res.sched_ind       = r_sch_v ? r_sch : '0;
      res.chan_is_full    = r_full;
      res.last            = r_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ready_ff <= 1'b0;
         full_ff  <= '0;
         aok_ff   <= '1;
         cur_ff   <= '0;
         pend_ff  <= '0;
         timer_ff <= '0;
         k_ff     <= '0;
         sel_ff   <= TMR_SCHED;
         hit_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
         full_ff  <= full_in;
         aok_ff   <= aok_in;
         cur_ff   <= cur_in;
         pend_ff  <= pend_in;
         timer_ff <= timer_in;
         k_ff     <= k_in;
         sel_ff   <= sel_in;
         hit_ff   <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      ge_a_ff <= ge_a_in;
      ge_b_ff <= ge_b_in;
   end

   `LCMS_CHECK(a_walk_in_range, walk |-> (CHAN_W'(k_ff) < cfg.count))
   `LCMS_CHECK_NEXT(a_last_ends_item, res_valid && res_ready && res.last, state_ff == S_IDLE)
   `LCMS_CHECK(a_exec_no_timeout, (state_ff == S_EXEC) |-> (res.error_code != ERR_TIMEOUT))

endmodule

/* design/lin_channel_mode_supervisor_unit.sv */
// Top level of the LIN channel mode supervisor: configuration, sequencer, result register.
//
// Supervises up to NUM_CHANNELS LIN channels. Each request carries one command
// (init, deinit, schedule request, mode request, schedule, wakeup or sleep
// confirmation, or tick) and yields one response, except an initialized tick,
// which yields one response per reported event followed by a closing response
// with last set. A small sequencer drives one shared 16-bit subtract and
// compare unit that serves every timer check and decrement. An ordinary
// command, once accepted, runs two compares on the addressed channel's
// timers, then a step that decides and updates state. A tick walks every
// channel in use: one with a zero timeout is skipped in a single step, and
// every other channel gets a step for the refused-schedule report and, for
// each of its three timers, a decrement then an expiry check. req_stall is high
// from acceptance until the last response has entered the output register, so
// a new request is taken while that response still waits on rsp_stall; a
// stalled output register also holds the sequencer. Configuration writes are
// always taken (csr_ready is tied high) and are meant to arrive only while
// the block is idle.
`include "lin_channel_mode_supervisor_unit_assert.svh"

module lin_channel_mode_supervisor_unit import lcms_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_payload,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cfg_type cfg;
   logic    busy;
   logic    res_valid;
   logic    res_ready;
   rsp_type res;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_payload_ff, rsp_payload_in;

   lcms_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // The sequencer only looks at req_valid while idle, so stall is its busy flag.
   lcms_core u_core (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_valid   (req_valid),
      .req_payload (req_payload),
      .busy        (busy),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res         (res)
   );

   assign req_stall = busy;

   // The output register takes a new response when empty or being drained.
   assign res_ready = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in   = 1'b1;
         rsp_payload_in = res;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   `LCMS_CHECK_NEXT(a_result_held, res_valid && !res_ready, res_valid)
   `LCMS_CHECK_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)
   `LCMS_CHECK_NEXT(a_result_loaded, res_valid && res_ready, rsp_valid)

endmodule
